// ===== rtl/wsm_pkg.sv =====
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared widths, register indexes, map modes and reset values for the
// workgroup id swizzle map.
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int WID_W   = 20;
    localparam int HEAD_W  = 7;
    localparam int QB_W    = 10;
    localparam int NH_W    = 8;
    localparam int BPH_W   = 11;
    localparam int ND_W    = 5;
    localparam int MODE_W  = 2;
    localparam int PB_W    = 18;
    localparam int CHUNK_W = 15;
    localparam int PROD_W  = ND_W + NH_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int MAX_HEADS  = 128;
    localparam int MAX_BLOCKS = 1024;
    localparam int MAX_DIES   = 16;

    localparam int RST_NUM_HEADS       = 8;
    localparam int RST_BLOCKS_PER_HEAD = 8;
    localparam int RST_NUM_DIES        = 8;
    localparam int RST_MAP_MODE        = 2;

    localparam int DIV1_STEPS = WID_W;
    localparam int QB_STEPS   = QB_W;
    localparam int HPD_STEPS  = NH_W;

    // input reg, divider load + steps, two short dividers, multiply, output
    localparam int PIPE_DEPTH = 1 + (DIV1_STEPS + 1) + 2 * (QB_STEPS + 1) + 2;

    typedef enum logic [1:0] {
        REG_NUM_HEADS       = 2'd0,
        REG_BLOCKS_PER_HEAD = 2'd1,
        REG_NUM_DIES        = 2'd2,
        REG_MAP_MODE        = 2'd3
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BLOCK_FIRST = 2'd0,
        MODE_HEAD_FIRST  = 2'd1,
        MODE_SWIZZLED    = 2'd2
    } map_mode_t;

endpackage

// ===== rtl/workgroup_id_swizzle_map.sv =====
// ----------------------------------------------------------------------------
// workgroup_id_swizzle_map
// Maps a linear workgroup id to batch, head and query-block indices with
// pipelined restoring dividers, one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel   signals                                     direction  transfer
//  command   start, busy, workgroup_id                   in         start && !busy
//  result    done, batch_index, head_index, query_block  out        done (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata,       in/out     psel && penable
//            prdata, pready                                         && pwrite
//
//  one id per cycle; busy stays low
//  the bit-per-stage dividers take 20 + 10 + 10 steps
//  derived divisors are registered from the config registers and settle after a register write
//  rst_n clears the valid chain and the registers to their reset values
//  the receiver cannot stall, so results leave on a fixed schedule
// ----------------------------------------------------------------------------
module workgroup_id_swizzle_map (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [wsm_pkg::WID_W-1:0]    workgroup_id,
    output logic                         done,
    output logic [wsm_pkg::WID_W-1:0]    batch_index,
    output logic [wsm_pkg::HEAD_W-1:0]   head_index,
    output logic [wsm_pkg::QB_W-1:0]     query_block,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [wsm_pkg::DATA_W-1:0]   pwdata,
    output logic [wsm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import wsm_pkg::*;

    // configuration registers
    logic [NH_W-1:0]    num_heads_reg;
    logic [BPH_W-1:0]   blocks_per_head_reg;
    logic [ND_W-1:0]    num_dies_reg;
    logic [MODE_W-1:0]  map_mode_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    // derived divisors
    logic [NH_W-1:0]    hq_next;
    logic [BPH_W-1:0]   bph_next;
    logic [ND_W-1:0]    nd_next;
    logic [NH_W-1:0]    hq_reg;
    logic [BPH_W-1:0]   bph_reg;
    logic [ND_W-1:0]    nd_reg;
    logic [PB_W-1:0]    per_batch_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CHUNK_W-1:0] d2_next;
    logic [CHUNK_W-1:0] d2_reg;

    // heads per die pipeline
    logic [ND_W-1:0]    hr_reg [0:HPD_STEPS];
    logic [NH_W-1:0]    hn_reg [0:HPD_STEPS];
    logic [ND_W:0]      ht     [0:HPD_STEPS-1];
    logic [ND_W:0]      hs     [0:HPD_STEPS-1];

    // input register
    logic               in_vld_reg;
    logic [WID_W-1:0]   in_wid_reg;

    // id / per_batch
    logic               v1_reg [0:DIV1_STEPS];
    logic [PB_W-1:0]    r1_reg [0:DIV1_STEPS];
    logic [WID_W-1:0]   n1_reg [0:DIV1_STEPS];
    logic [PB_W:0]      t1     [0:DIV1_STEPS-1];
    logic [PB_W:0]      s1     [0:DIV1_STEPS-1];

    // remainder / mode divisor
    logic               v2_reg [0:QB_STEPS];
    logic [CHUNK_W-1:0] r2_reg [0:QB_STEPS];
    logic [QB_W-1:0]    n2_reg [0:QB_STEPS];
    logic [WID_W-1:0]   b2_reg [0:QB_STEPS];
    logic [CHUNK_W:0]   t2     [0:QB_STEPS-1];
    logic [CHUNK_W:0]   s2     [0:QB_STEPS-1];

    // chunk offset / dies
    logic               v3_reg [0:QB_STEPS];
    logic [ND_W-1:0]    r3_reg [0:QB_STEPS];
    logic [QB_W-1:0]    n3_reg [0:QB_STEPS];
    logic [WID_W-1:0]   b3_reg [0:QB_STEPS];
    logic [QB_W-1:0]    q3_reg [0:QB_STEPS];
    logic [QB_W-1:0]    m3_reg [0:QB_STEPS];
    logic [ND_W:0]      t3     [0:QB_STEPS-1];
    logic [ND_W:0]      s3     [0:QB_STEPS-1];

    // multiply stage
    logic               vm_reg;
    logic [WID_W-1:0]   bm_reg;
    logic [QB_W-1:0]    gm_reg;
    logic [QB_W-1:0]    rm_reg;
    logic [QB_W-1:0]    tm_reg;
    logic [PROD_W-1:0]  pm_reg;

    // output stage
    logic [SUM_W-1:0]   sum;
    logic [HEAD_W-1:0]  head_next;
    logic [QB_W-1:0]    tile_next;
    logic               done_reg;
    logic [WID_W-1:0]   batch_index_reg;
    logic [HEAD_W-1:0]  head_index_reg;
    logic [QB_W-1:0]    query_block_reg;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_heads_reg       <= NH_W'(RST_NUM_HEADS);
            blocks_per_head_reg <= BPH_W'(RST_BLOCKS_PER_HEAD);
            num_dies_reg        <= ND_W'(RST_NUM_DIES);
            map_mode_reg        <= MODE_W'(RST_MAP_MODE);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_NUM_HEADS:       num_heads_reg       <= pwdata[NH_W-1:0];
                REG_BLOCKS_PER_HEAD: blocks_per_head_reg <= pwdata[BPH_W-1:0];
                REG_NUM_DIES:        num_dies_reg        <= pwdata[ND_W-1:0];
                REG_MAP_MODE:        map_mode_reg        <= pwdata[MODE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_NUM_HEADS:       prdata = DATA_W'(num_heads_reg);
            REG_BLOCKS_PER_HEAD: prdata = DATA_W'(blocks_per_head_reg);
            REG_NUM_DIES:        prdata = DATA_W'(num_dies_reg);
            REG_MAP_MODE:        prdata = DATA_W'(map_mode_reg);
        endcase
    end

    // zero is taken as one, large values saturate
    always_comb
    begin
        hq_next = num_heads_reg;
        if (num_heads_reg == '0)
            hq_next = NH_W'(1);
        else if (num_heads_reg > NH_W'(MAX_HEADS))
            hq_next = NH_W'(MAX_HEADS);

        bph_next = blocks_per_head_reg;
        if (blocks_per_head_reg == '0)
            bph_next = BPH_W'(1);
        else if (blocks_per_head_reg > BPH_W'(MAX_BLOCKS))
            bph_next = BPH_W'(MAX_BLOCKS);

        nd_next = num_dies_reg;
        if (num_dies_reg == '0)
            nd_next = ND_W'(1);
        else if (num_dies_reg > ND_W'(MAX_DIES))
            nd_next = ND_W'(MAX_DIES);
    end

    always_comb
    begin
        unique case (map_mode_t'(map_mode_reg))
            MODE_HEAD_FIRST:  d2_next = CHUNK_W'(bph_reg);
            MODE_BLOCK_FIRST: d2_next = CHUNK_W'(hq_reg);
            default:          d2_next = chunk_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hq_reg        <= NH_W'(RST_NUM_HEADS);
            bph_reg       <= BPH_W'(RST_BLOCKS_PER_HEAD);
            nd_reg        <= ND_W'(RST_NUM_DIES);
            per_batch_reg <= PB_W'(RST_NUM_HEADS * RST_BLOCKS_PER_HEAD);
            chunk_reg     <= CHUNK_W'(RST_NUM_DIES * RST_BLOCKS_PER_HEAD);
            d2_reg        <= CHUNK_W'(RST_NUM_DIES * RST_BLOCKS_PER_HEAD);
        end
        else
        begin
            hq_reg        <= hq_next;
            bph_reg       <= bph_next;
            nd_reg        <= nd_next;
            per_batch_reg <= PB_W'(PB_W'(hq_next) * PB_W'(bph_next));
            chunk_reg     <= CHUNK_W'(CHUNK_W'(nd_next) * CHUNK_W'(bph_next));
            d2_reg        <= d2_next;
        end
    end

    // heads per die, free running on the settled registers
    always_comb
    begin
        for (int j = 0; j < HPD_STEPS; j++)
        begin
            ht[j] = {hr_reg[j], hn_reg[j][NH_W-1]};
            hs[j] = ht[j] - {1'b0, nd_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        hr_reg[0] <= '0;
        hn_reg[0] <= hq_reg;
        for (int j = 0; j < HPD_STEPS; j++)
        begin
            if (!hs[j][ND_W])
            begin
                hr_reg[j+1] <= hs[j][ND_W-1:0];
                hn_reg[j+1] <= {hn_reg[j][NH_W-2:0], 1'b1};
            end
            else
            begin
                hr_reg[j+1] <= ht[j][ND_W-1:0];
                hn_reg[j+1] <= {hn_reg[j][NH_W-2:0], 1'b0};
            end
        end
    end

    // divider trial subtractions
    always_comb
    begin
        for (int j = 0; j < DIV1_STEPS; j++)
        begin
            t1[j] = {r1_reg[j], n1_reg[j][WID_W-1]};
            s1[j] = t1[j] - {1'b0, per_batch_reg};
        end
        for (int j = 0; j < QB_STEPS; j++)
        begin
            t2[j] = {r2_reg[j], n2_reg[j][QB_W-1]};
            s2[j] = t2[j] - {1'b0, d2_reg};
            t3[j] = {r3_reg[j], n3_reg[j][QB_W-1]};
            s3[j] = t3[j] - {1'b0, nd_reg};
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            for (int j = 0; j <= DIV1_STEPS; j++)
                v1_reg[j] <= 1'b0;
            for (int j = 0; j <= QB_STEPS; j++)
            begin
                v2_reg[j] <= 1'b0;
                v3_reg[j] <= 1'b0;
            end
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start & ~busy;
            v1_reg[0]  <= in_vld_reg;
            for (int j = 0; j < DIV1_STEPS; j++)
                v1_reg[j+1] <= v1_reg[j];
            v2_reg[0] <= v1_reg[DIV1_STEPS];
            v3_reg[0] <= v2_reg[QB_STEPS];
            for (int j = 0; j < QB_STEPS; j++)
            begin
                v2_reg[j+1] <= v2_reg[j];
                v3_reg[j+1] <= v3_reg[j];
            end
            vm_reg   <= v3_reg[QB_STEPS];
            done_reg <= vm_reg;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (start & ~busy)
            in_wid_reg <= workgroup_id;

        r1_reg[0] <= '0;
        n1_reg[0] <= in_wid_reg;
        for (int j = 0; j < DIV1_STEPS; j++)
        begin
            if (!s1[j][PB_W])
            begin
                r1_reg[j+1] <= s1[j][PB_W-1:0];
                n1_reg[j+1] <= {n1_reg[j][WID_W-2:0], 1'b1};
            end
            else
            begin
                r1_reg[j+1] <= t1[j][PB_W-1:0];
                n1_reg[j+1] <= {n1_reg[j][WID_W-2:0], 1'b0};
            end
        end

        // quotient fits in QB_W bits, so the top remainder bits preload
        r2_reg[0] <= CHUNK_W'(r1_reg[DIV1_STEPS][PB_W-1:QB_W]);
        n2_reg[0] <= r1_reg[DIV1_STEPS][QB_W-1:0];
        b2_reg[0] <= n1_reg[DIV1_STEPS];
        for (int j = 0; j < QB_STEPS; j++)
        begin
            b2_reg[j+1] <= b2_reg[j];
            if (!s2[j][CHUNK_W])
            begin
                r2_reg[j+1] <= s2[j][CHUNK_W-1:0];
                n2_reg[j+1] <= {n2_reg[j][QB_W-2:0], 1'b1};
            end
            else
            begin
                r2_reg[j+1] <= t2[j][CHUNK_W-1:0];
                n2_reg[j+1] <= {n2_reg[j][QB_W-2:0], 1'b0};
            end
        end

        r3_reg[0] <= ND_W'(r2_reg[QB_STEPS][CHUNK_W-1:QB_W]);
        n3_reg[0] <= r2_reg[QB_STEPS][QB_W-1:0];
        b3_reg[0] <= b2_reg[QB_STEPS];
        q3_reg[0] <= n2_reg[QB_STEPS];
        m3_reg[0] <= r2_reg[QB_STEPS][QB_W-1:0];
        for (int j = 0; j < QB_STEPS; j++)
        begin
            b3_reg[j+1] <= b3_reg[j];
            q3_reg[j+1] <= q3_reg[j];
            m3_reg[j+1] <= m3_reg[j];
            if (!s3[j][ND_W])
            begin
                r3_reg[j+1] <= s3[j][ND_W-1:0];
                n3_reg[j+1] <= {n3_reg[j][QB_W-2:0], 1'b1};
            end
            else
            begin
                r3_reg[j+1] <= t3[j][ND_W-1:0];
                n3_reg[j+1] <= {n3_reg[j][QB_W-2:0], 1'b0};
            end
        end

        // lane times heads per die
        bm_reg <= b3_reg[QB_STEPS];
        gm_reg <= q3_reg[QB_STEPS];
        rm_reg <= m3_reg[QB_STEPS];
        tm_reg <= n3_reg[QB_STEPS];
        pm_reg <= PROD_W'(PROD_W'(r3_reg[QB_STEPS]) * PROD_W'(hn_reg[HPD_STEPS]));

        batch_index_reg <= bm_reg;
        head_index_reg  <= head_next;
        query_block_reg <= tile_next;
    end

    always_comb
    begin
        sum = {1'b0, pm_reg} + SUM_W'(gm_reg);
        unique case (map_mode_t'(map_mode_reg))
            MODE_HEAD_FIRST:
            begin
                head_next = gm_reg[HEAD_W-1:0];
                tile_next = rm_reg;
            end
            MODE_BLOCK_FIRST:
            begin
                head_next = rm_reg[HEAD_W-1:0];
                tile_next = gm_reg;
            end
            default:
            begin
                // swizzled, unused code too; clamp to the last head and tile
                if (sum >= SUM_W'(hq_reg))
                    head_next = HEAD_W'(hq_reg - NH_W'(1));
                else
                    head_next = sum[HEAD_W-1:0];
                if (BPH_W'(tm_reg) >= bph_reg)
                    tile_next = QB_W'(bph_reg - BPH_W'(1));
                else
                    tile_next = tm_reg;
            end
        endcase
    end

    assign done        = done_reg;
    assign batch_index = batch_index_reg;
    assign head_index  = head_index_reg;
    assign query_block = query_block_reg;

    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("accepted id produced no result");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without an accepted id");

    a_per_batch: assert property (@(posedge clk) disable iff (!rst_n)
        per_batch_reg == PB_W'(PB_W'(hq_reg) * PB_W'(bph_reg)))
        else $error("per-batch divisor out of step with registers");

    a_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_reg == CHUNK_W'(CHUNK_W'(nd_reg) * CHUNK_W'(bph_reg)))
        else $error("chunk divisor out of step with registers");

endmodule
